FILE: sv/cha_pkg.sv
// Shared package for the convex hull area block.
// Holds default sizes, result field widths and the queue flag type.
// No dependencies.
package cha_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;

  localparam int AREA_W  = 33;
  localparam int COUNT_W = 11;
  localparam int OUT_W   = ((AREA_W + COUNT_W + 7) / 8) * 8;

  typedef struct packed {
    logic last;
    logic keep;
  } cha_flags_t;

endpackage

FILE: sv/cha_fifo.sv
// Short request queue between the front and back parts.
// Depends on cha_pkg for the flag type.
module cha_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  cha_pkg::cha_flags_t push_flags,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output cha_pkg::cha_flags_t pop_flags
);
  import cha_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  cha_flags_t       flag_q [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full      = (fill == CW'(DEPTH));
  assign pop_valid = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_data  = data_q[rd_ptr];
  assign pop_flags = flag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_q[wr_ptr] <= push_data;
      flag_q[wr_ptr] <= push_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: sv/cha_front.sv
// Front part: accepts points and marks those that still fit in the store.
// Depends on cha_pkg and feeds cha_fifo.
module cha_front #(
  parameter int MAX_POINTS = cha_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cha_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [2*COORD_BITS-1:0] point,
  input  logic                    s_tlast,
  input  logic                    q_full,
  output logic                    q_push,
  output logic [2*COORD_BITS-1:0] q_data,
  output cha_pkg::cha_flags_t     q_flags
);
  import cha_pkg::*;

  localparam int CNTW = $clog2(MAX_POINTS + 1);

  logic [CNTW-1:0] set_count;
  logic            keep;

  assign keep          = (set_count < CNTW'(MAX_POINTS));
  assign s_tready      = !q_full;
  assign q_push        = s_tvalid && !q_full;
  assign q_data        = point;
  assign q_flags.last  = s_tlast;
  assign q_flags.keep  = keep;

  // Points beyond the store size are still passed on, marked as dropped,
  // so that a last flag on them still starts the computation.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_count <= '0;
    end else if (q_push) begin
      if (s_tlast) begin
        set_count <= '0;
      end else if (keep) begin
        set_count <= set_count + 1'b1;
      end
    end
  end

endmodule

FILE: sv/cha_back.sv
// Back part: stores the points, tracks the anchor and wraps the hull
// with a shared cross-product unit. Depends on cha_pkg.
module cha_back #(
  parameter int MAX_POINTS = cha_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cha_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [2*COORD_BITS-1:0] q_data,
  input  cha_pkg::cha_flags_t     q_flags,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [cha_pkg::OUT_W-1:0] m_tdata
);
  import cha_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int CRW  = PW + 1;
  localparam int ACCW = 2 * CW + 3;
  localparam int IW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_AMUL = 3'd4;
  localparam logic [2:0] S_AADD = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2*CW-1:0] mem [MAX_POINTS];
  logic [2*CW-1:0] rdata;

  logic [2:0]      state;
  logic [CNTW-1:0] n;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   idx_last;
  logic [CNTW-1:0] count;
  logic [ACCW-1:0] acc;
  logic [AREA_W-1:0]  area_out;
  logic [COUNT_W-1:0] count_out;

  logic signed [CW-1:0] ax, ay, cur_x, cur_y, cand_x, cand_y, p_x, p_y;
  logic signed [CW-1:0] qx, qy, rx, ry;
  logic signed [CW-1:0] anc_x_new, anc_y_new;
  logic                 cand_valid;
  logic                 wr_en;

  logic signed [DW-1:0] dcx, dcy, dpx, dpy;
  logic signed [PW-1:0] prod1, prod2;
  logic signed [CRW-1:0] cr;
  logic [DW:0]          dist_c, dist_p;
  logic                 p_eq_cur;

  function automatic logic [DW-1:0] absd(input logic signed [DW-1:0] d);
    absd = d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  assign qx = q_data[CW-1:0];
  assign qy = q_data[2*CW-1:CW];
  assign rx = rdata[CW-1:0];
  assign ry = rdata[2*CW-1:CW];

  assign q_pop    = (state == S_LOAD);
  assign wr_en    = q_pop && q_valid && q_flags.keep;
  assign idx_last = IW'(n - 1'b1);
  assign cr       = CRW'(prod1) - CRW'(prod2);

  always_comb begin
    anc_x_new = ax;
    anc_y_new = ay;
    if (wr_en && ((n == '0) || (qy < ay) || ((qy == ay) && (qx < ax)))) begin
      anc_x_new = qx;
      anc_y_new = qy;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IW'(n)] <= q_data;
    end
    rdata <= mem[idx];
  end

  always_comb begin
    dcx = DW'(cand_x) - DW'(cur_x);
    dcy = DW'(cand_y) - DW'(cur_y);
    dpx = DW'(rx) - DW'(cur_x);
    dpy = DW'(ry) - DW'(cur_y);
  end

  // Shared multiplier pair: candidate test during the scan, area term
  // for the new edge after it.
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod1    <= dcx * dpy;
      prod2    <= dcy * dpx;
      dist_c   <= (DW+1)'(absd(dcx)) + (DW+1)'(absd(dcy));
      dist_p   <= (DW+1)'(absd(dpx)) + (DW+1)'(absd(dpy));
      p_eq_cur <= (rx == cur_x) && (ry == cur_y);
      p_x      <= rx;
      p_y      <= ry;
    end else if (state == S_AMUL) begin
      prod1 <= (DW'(cur_x) - DW'(ax)) * (DW'(cand_y) - DW'(ay));
      prod2 <= (DW'(cur_y) - DW'(ay)) * (DW'(cand_x) - DW'(ax));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      n          <= '0;
      idx        <= '0;
      count      <= '0;
      acc        <= '0;
      cand_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      ax         <= '0;
      ay         <= '0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (q_valid) begin
            ax <= anc_x_new;
            ay <= anc_y_new;
            if (q_flags.keep) begin
              n <= n + 1'b1;
            end
            if (q_flags.last) begin
              cur_x      <= anc_x_new;
              cur_y      <= anc_y_new;
              count      <= CNTW'(1);
              acc        <= '0;
              cand_valid <= 1'b0;
              idx        <= '0;
              state      <= S_RD;
            end
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: state <= S_DEC;
        S_DEC: begin
          if (!p_eq_cur && (!cand_valid || cr < 0 || (cr == 0 && dist_p > dist_c))) begin
            cand_x     <= p_x;
            cand_y     <= p_y;
            cand_valid <= 1'b1;
          end
          if (idx == idx_last) begin
            state <= S_AMUL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_AMUL: begin
          // The wrap ends when no other point exists or it is back at the anchor.
          if (!cand_valid || (cand_x == ax && cand_y == ay)) begin
            state <= S_DONE;
          end else begin
            state <= S_AADD;
          end
        end
        S_AADD: begin
          acc        <= acc + ACCW'(cr);
          cur_x      <= cand_x;
          cur_y      <= cand_y;
          count      <= count + 1'b1;
          cand_valid <= 1'b0;
          idx        <= '0;
          state      <= S_RD;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            n     <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      if (count >= CNTW'(3)) begin
        area_out  <= AREA_W'(acc);
        count_out <= COUNT_W'(count);
      end else begin
        area_out  <= '0;
        count_out <= '0;
      end
    end
  end

  assign m_tdata = {(OUT_W - AREA_W - COUNT_W)'(0), count_out, area_out};

endmodule

FILE: sv/convex_hull_area.sv
// Top level of the convex hull area block.
// Depends on cha_pkg, cha_front, cha_fifo and cha_back.
//
// Input channel (s_*): one point per request, x in the low half of
// s_tdata and y in the high half; s_tlast marks the final point of a set.
// Output channel (m_*): one request per set, carrying twice the hull area
// and the number of hull vertices. A hull with fewer than three vertices
// gives zero for both.
// Points are taken one per cycle, while the queue has room, into a
// four-entry request queue. The back part stores each kept point and
// keeps the bottom-most, leftmost point as anchor while loading. After
// the last point it wraps the hull: each wrap step scans all n stored
// points, each through a memory read, a multiply and a decide state,
// and then closes the step with an area multiply and an add state.
// The single memory read port and the shared multiplier pair keep the
// scan to one point at a time. Points of the next set wait in the
// queue and s_tready falls once it is full.
// Reset clears the queue, the point count and the output valid; the
// store itself is not cleared. When the receiver stalls the result holds
// in the output register; the back part goes on loading and wrapping the
// next set and then waits with that result until the register is free.
module convex_hull_area #(
  parameter int MAX_POINTS = cha_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cha_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // point_x, point_y, zero padding
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // doubled_area (33), hull_count (11), zero padding
  output logic [cha_pkg::OUT_W-1:0] m_tdata
);
  import cha_pkg::*;

  localparam int PTW = 2 * COORD_BITS;

  logic            q_push, q_full, q_valid, q_pop;
  logic [PTW-1:0]  push_data, pop_data;
  cha_flags_t      push_flags, pop_flags;

  cha_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .point(s_tdata[PTW-1:0]), .s_tlast(s_tlast),
    .q_full(q_full), .q_push(q_push), .q_data(push_data), .q_flags(push_flags)
  );

  cha_fifo #(.WIDTH(PTW), .DEPTH(4)) u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(push_data), .push_flags(push_flags),
    .full(q_full), .pop_valid(q_valid), .pop(q_pop),
    .pop_data(pop_data), .pop_flags(pop_flags)
  );

  cha_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(pop_data), .q_flags(pop_flags),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

FILE: sv/cha_checker.sv
// Port-level checks for convex_hull_area, attached by bind.
// Depends on cha_pkg for the result layout.
module cha_checker (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [cha_pkg::OUT_W-1:0] m_tdata
);
  import cha_pkg::*;

  logic [COUNT_W-1:0] cnt;
  logic [AREA_W-1:0]  area;

  assign area = m_tdata[AREA_W-1:0];
  assign cnt  = m_tdata[AREA_W+COUNT_W-1:AREA_W];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cnt == '0 |-> area == '0)
    else $error("degenerate hull with nonzero area");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt != COUNT_W'(1) && cnt != COUNT_W'(2))
    else $error("hull with one or two vertices");

endmodule

bind convex_hull_area cha_checker u_cha_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: tb/convex_hull_area_tb.sv
// Testbench for the convex hull area block: streams point sets in and
// checks twice the hull area and the vertex count against its own Graham scan.
// Depends on cha_pkg and the convex_hull_area top level.
module convex_hull_area_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cha_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int IN_W = 32;
  localparam int WATCHDOG = 400000;

  typedef struct {
    logic [AREA_W-1:0]  area;
    logic [COUNT_W-1:0] count;
  } hull_result_t;

  // Scoreboard: keeps the current point set and predicts the hull of it.
  class hull_scoreboard;
    longint xs[NPTS];
    longint ys[NPTS];
    int n;
    hull_result_t pending[$];
    int errors;

    // Sign of (a - o) x (b - o); products fit comfortably in 64 bits here.
    function int turn(int o, int a, int b);
      longint c;
      c = (xs[a] - xs[o]) * (ys[b] - ys[o]) - (ys[a] - ys[o]) * (xs[b] - xs[o]);
      return (c > 0) ? 1 : (c < 0) ? -1 : 0;
    endfunction

    function longint span(int a, int o);
      longint dx, dy;
      dx = xs[a] - xs[o];
      dy = ys[a] - ys[o];
      return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
    endfunction

    function hull_result_t wrap_hull();
      hull_result_t r;
      int ord[$];
      int kept[$];
      int stk[$];
      int anc, j, s;
      longint acc;
      anc = 0;
      for (int i = 1; i < n; i++)
        if (ys[i] < ys[anc] || (ys[i] == ys[anc] && xs[i] < xs[anc])) anc = i;
      // Insertion sort by angle about the anchor, nearer first on a tie.
      for (int i = 0; i < n; i++) begin
        if (xs[i] == xs[anc] && ys[i] == ys[anc]) continue;
        j = ord.size();
        ord = {ord, i};
        while (j > 0) begin
          s = turn(anc, i, ord[j-1]);
          if (s > 0 || (s == 0 && span(i, anc) < span(ord[j-1], anc))) begin
            ord[j] = ord[j-1];
            j--;
          end else break;
        end
        ord[j] = i;
      end
      for (int i = 0; i < ord.size(); i++)
        if (i + 1 == ord.size() || turn(anc, ord[i], ord[i+1]) != 0)
          kept = {kept, ord[i]};
      r.area = '0;
      r.count = '0;
      if (kept.size() < 2) return r;
      stk = {anc, kept[0], kept[1]};
      for (int i = 2; i < kept.size(); i++) begin
        while (stk.size() > 2 && turn(stk[stk.size()-2], stk[stk.size()-1], kept[i]) <= 0)
          void'(stk.pop_back());
        stk = {stk, kept[i]};
      end
      acc = 0;
      for (int i = 1; i + 1 < stk.size(); i++)
        acc += (xs[stk[i]] - xs[anc]) * (ys[stk[i+1]] - ys[anc])
             - (ys[stk[i]] - ys[anc]) * (xs[stk[i+1]] - xs[anc]);
      r.area = acc[AREA_W-1:0];
      r.count = COUNT_W'(stk.size());
      return r;
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      if (n < NPTS) begin
        xs[n] = x;
        ys[n] = y;
        n++;
      end
      if (last) begin
        pending = {pending, wrap_hull()};
        n = 0;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      hull_result_t e;
      logic [AREA_W-1:0]  a;
      logic [COUNT_W-1:0] c;
      a = data[AREA_W-1:0];
      c = data[AREA_W +: COUNT_W];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result area=%0d count=%0d", $time, a, c);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a !== e.area) begin
        $display("%0t: area expected %0d actual %0d", $time, e.area, a);
        errors++;
      end
      if (c !== e.count) begin
        $display("%0t: count expected %0d actual %0d", $time, e.count, c);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tlast;
  logic [IN_W-1:0] s_tdata;   // point_x, point_y
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;  // doubled_area, hull_count, zero padding

  hull_scoreboard hulls;
  int idle_cycles;
  bit long_hold;

  convex_hull_area i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls in runs, with one long hold-off while the
  // sender keeps offering requests so that the input queue fills up.
  initial begin
    int mode;
    bit held;
    held = 1'b0;
    m_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold && !held) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        held = 1'b1;
      end
      mode = $urandom_range(0, 3);
      for (int k = $urandom_range(1, 40); k > 0; k--) begin
        m_tready <= (mode == 0) ? 1'b1 : (mode == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
        @(posedge clk);
      end
    end
  end

  // Result monitor and watchdog on requests in either direction.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) hulls.check_result(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  int gap_left;

  // Sends one point; bursts of back-to-back requests are now and then separated by gaps.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    if (gap_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      gap_left = $urandom_range(1, 30);
    end
    gap_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    hulls.note_point(x, y, last);
  endtask

  task automatic send_set(input int cnt, input int span_sel);
    logic signed [15:0] x, y;
    int lim;
    lim = (span_sel == 0) ? 3 : (span_sel == 1) ? 200 : 32767;
    for (int i = 0; i < cnt; i++) begin
      if (span_sel == 3) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(0, 2 * lim) - lim);
        y = 16'($urandom_range(0, 2 * lim) - lim);
      end
      send_point(x, y, i == cnt - 1);
    end
  endtask

  initial begin
    int sent;
    hulls = new();
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    long_hold = 1'b0;
    gap_left = 0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single point, two points, collinear, anchor duplicates,
    // a square at the coordinate extremes, and a square with repeated corners.
    send_point(16'sd5, -16'sd3, 1'b1);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd9, 16'sd4, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(16'sd4, 16'sd4, 1'b1);
    send_point(16'sd7, 16'sd7, 1'b0);
    send_point(16'sd7, 16'sd7, 1'b0);
    send_point(16'sd7, 16'sd7, 1'b1);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, 16'sd32767, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd5, 16'sd0, 1'b0);
    send_point(16'sd5, 16'sd0, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd0, 16'sd5, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd5, 1'b1);

    // Random sets, mostly small; the hold-off starts once more than 300 points are sent.
    sent = 0;
    while (sent < 900) begin
      int cnt;
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (sent > 300) long_hold = 1'b1;
      send_set(cnt, $urandom_range(0, 3));
      sent += cnt;
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    while (hulls.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (hulls.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/cha_pkg.sv
sv/cha_fifo.sv
sv/cha_front.sv
sv/cha_back.sv
sv/convex_hull_area.sv
sv/cha_checker.sv
tb/convex_hull_area_tb.sv
